@@ sv/i2c_master_bit_sequencer_macros.svh @@
// Assertion helpers used by the sequencer RTL.
`ifndef I2C_MASTER_BIT_SEQUENCER_MACROS_SVH
`define I2C_MASTER_BIT_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define I2CMS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define I2CMS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/i2cms_pkg.sv @@
package i2cms_pkg;

	localparam int DATA_BITS = 8;

	// Command codes; CMD_NONE also marks the idle state
	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_STOP  = 3'd2;
	localparam logic [2:0] CMD_WRITE = 3'd3;
	localparam logic [2:0] CMD_READ  = 3'd4;
	localparam logic [2:0] CMD_SACK  = 3'd5;
	localparam logic [2:0] CMD_RACK  = 3'd6;

	typedef struct packed {
		logic [2:0]           op;
		logic [DATA_BITS-1:0] data_byte;
		logic                 ack_value;
		logic                 sda_in;
	} req_t;

	typedef struct packed {
		logic                 scl_level;
		logic                 sda_level;
		logic                 busy_res;
		logic                 done_res;
		logic [DATA_BITS-1:0] read_data;
		logic                 ack_seen;
		logic                 command_ignored;
	} rsp_t;

	typedef struct packed {
		logic [2:0]           cmd;
		logic [4:0]           phase;
		logic [DATA_BITS-1:0] shreg;
		logic                 scl;
		logic                 sda;
		logic [DATA_BITS-1:0] rx_byte;
		logic                 ack;
	} seq_state_t;

	localparam seq_state_t STATE_RESET = '{
		cmd:     CMD_NONE,
		phase:   5'd0,
		shreg:   '0,
		scl:     1'b1,
		sda:     1'b1,
		rx_byte: '0,
		ack:     1'b1
	};

	// Number of phases of each command
	function automatic logic [4:0] seq_len(input logic [2:0] cmd);
		logic [4:0] len;
		case (cmd)
			CMD_START: len = 5'd4;
			CMD_STOP:  len = 5'd3;
			CMD_WRITE: len = 5'(3 * DATA_BITS);
			CMD_READ:  len = 5'(1 + 2 * DATA_BITS);
			CMD_SACK:  len = 5'd3;
			CMD_RACK:  len = 5'd4;
			default:   len = 5'd0;
		endcase
		return len;
	endfunction

	// Phase divided by three, exact for phases below 32
	function automatic logic [3:0] div3(input logic [4:0] p);
		logic [8:0] prod;
		prod = {4'b0, p} * 9'd11;
		return prod[8:5];
	endfunction

endpackage

@@ sv/i2cms_step.sv @@
module i2cms_step (
	input  i2cms_pkg::seq_state_t cur,
	input  i2cms_pkg::req_t       req,
	output i2cms_pkg::seq_state_t nxt,
	output i2cms_pkg::rsp_t       res
);
	import i2cms_pkg::*;

	logic       busy;
	logic       done;
	logic       ignored;
	logic [4:0] p;
	logic [3:0] wbit;
	logic [4:0] tri_bit;
	logic [4:0] wsub;
	logic [4:0] rq;
	logic [2:0] rbit;
	logic [4:0] phase_inc;

	always_comb begin
		nxt     = cur;
		busy    = 1'b0;
		done    = 1'b0;
		ignored = 1'b0;

		// Take a new command only when idle
		if (cur.cmd == CMD_NONE) begin
			if (req.op >= CMD_START && req.op <= CMD_RACK) begin
				nxt.cmd   = req.op;
				nxt.phase = 5'd0;
				case (req.op)
					CMD_WRITE: nxt.shreg = req.data_byte;
					CMD_SACK:  nxt.shreg = {{(DATA_BITS-1){1'b0}}, req.ack_value};
					default:   nxt.shreg = '0;
				endcase
			end
		end else if (req.op != CMD_NONE) begin
			ignored = 1'b1;
		end

		p       = nxt.phase;
		wbit    = div3(p);
		tri_bit = {wbit, 1'b0} + {1'b0, wbit};
		wsub    = p - tri_bit;
		rq      = p - 5'd1;
		rbit    = rq[3:1];
		phase_inc = p + 5'd1;

		if (nxt.cmd != CMD_NONE) begin
			case (nxt.cmd)
				CMD_START: begin
					case (p)
						5'd0:    nxt.sda = 1'b1;
						5'd1:    nxt.scl = 1'b1;
						5'd2:    nxt.sda = 1'b0;
						default: nxt.scl = 1'b0;
					endcase
				end
				CMD_STOP: begin
					case (p)
						5'd0:    nxt.sda = 1'b0;
						5'd1:    nxt.scl = 1'b1;
						default: nxt.sda = 1'b1;
					endcase
				end
				CMD_WRITE: begin
					// MSB first: bit index is seven minus the bit count
					case (wsub[1:0])
						2'd0:    nxt.sda = nxt.shreg[~wbit[2:0]];
						2'd1:    nxt.scl = 1'b1;
						default: nxt.scl = 1'b0;
					endcase
				end
				CMD_READ: begin
					if (p == 5'd0) begin
						nxt.sda = 1'b1;
					end else if (!rq[0]) begin
						nxt.scl = 1'b1;
						nxt.shreg[~rbit] = nxt.shreg[~rbit] | req.sda_in;
					end else begin
						nxt.scl = 1'b0;
					end
				end
				CMD_SACK: begin
					case (p)
						5'd0:    nxt.sda = nxt.shreg[0];
						5'd1:    nxt.scl = 1'b1;
						default: nxt.scl = 1'b0;
					endcase
				end
				CMD_RACK: begin
					case (p)
						5'd0:    nxt.sda = 1'b1;
						5'd1:    nxt.scl = 1'b1;
						5'd2:    nxt.ack = req.sda_in;
						default: nxt.scl = 1'b0;
					endcase
				end
				default: ;
			endcase

			if (phase_inc >= seq_len(nxt.cmd)) begin
				if (nxt.cmd == CMD_READ)
					nxt.rx_byte = nxt.shreg;
				done      = 1'b1;
				nxt.cmd   = CMD_NONE;
				nxt.phase = 5'd0;
			end else begin
				busy      = 1'b1;
				nxt.phase = phase_inc;
			end
		end

		res.scl_level       = nxt.scl;
		res.sda_level       = nxt.sda;
		res.busy_res        = busy;
		res.done_res        = done;
		res.read_data       = nxt.rx_byte;
		res.ack_seen        = nxt.ack;
		res.command_ignored = ignored;
	end

endmodule

@@ sv/i2cms_out_reg.sv @@
module i2cms_out_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  i2cms_pkg::rsp_t din,
	input  logic            rsp_stall,
	output logic            rsp_valid,
	output i2cms_pkg::rsp_t rsp
);
	import i2cms_pkg::*;

	logic valid_q;
	rsp_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= din;
		end
	end

	assign rsp_valid = valid_q;
	assign rsp       = data_q;

endmodule

@@ sv/i2c_master_bit_sequencer.sv @@
// I2C master bit sequencer: every accepted request is one bus-phase tick and
// yields exactly one result in the next cycle, giving the SCL and SDA levels to
// drive for that phase, busy and done flags, the last byte read, the last
// sampled ack and a flag for a command dropped while busy. Start takes 4
// ticks, stop 3, write byte 24, read byte 17, send ack 3, receive ack 4. A
// request is taken every cycle (one tick per clock) as long as the result
// register is free or being emptied in the same cycle; the only limit on rate
// is the consumer's stall on the result side.
module i2c_master_bit_sequencer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  i2cms_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output i2cms_pkg::rsp_t rsp
);
	import i2cms_pkg::*;

	`include "i2c_master_bit_sequencer_macros.svh"

	seq_state_t state_q;
	seq_state_t state_nxt;
	rsp_t       step_res;
	logic       accept;

	assign req_stall = rsp_valid && rsp_stall;
	assign accept    = req_valid && !req_stall;

	i2cms_step u_step (
		.cur (state_q),
		.req (req),
		.nxt (state_nxt),
		.res (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	i2cms_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.din       (step_res),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	`I2CMS_ASSERT_NOW(a_stall_back, rsp_valid && rsp_stall, req_stall, "held result not back-pressured")
	`I2CMS_ASSERT_NOW(a_busy_done, rsp_valid, !(rsp.busy_res && rsp.done_res), "busy and done together")
	`I2CMS_ASSERT_NOW(a_idle_phase, state_q.cmd == CMD_NONE, state_q.phase == 5'd0, "idle with phase")
	`I2CMS_ASSERT_NEXT(a_result, accept, rsp_valid, "accepted request gave no result")

endmodule

@@ tb/sv/i2c_master_bit_sequencer_test.sv @@
`timescale 1ns / 100ps

module i2c_master_bit_sequencer_test;
	import i2cms_pkg::*;

	// op code seven is not a command; idle ignores it, busy flags it
	localparam logic [2:0] OP_UNUSED   = 3'd7;
	localparam int         CYCLE_LIMIT = 400000;
	localparam int         RANDOM_TICKS = 700;

	class phase_board;
		rsp_t        levels_due[$];
		logic [2:0]  cmd_run;
		logic [4:0]  phase_idx;
		logic [DATA_BITS-1:0] shifter;
		logic        scl;
		logic        sda;
		logic [DATA_BITS-1:0] rx_byte;
		logic        ack_lvl;
		int          mismatches;
		int          checked;
		int          dropped;
		int          finished[8];

		function new();
			cmd_run = CMD_NONE;
			phase_idx = '0;
			shifter = '0;
			scl = 1'b1;
			sda = 1'b1;
			rx_byte = '0;
			ack_lvl = 1'b1;
			mismatches = 0;
			checked = 0;
			dropped = 0;
			foreach (finished[i]) finished[i] = 0;
		endfunction

		function int phase_total(input logic [2:0] c);
			case (c)
				CMD_START: return 4;
				CMD_STOP:  return 3;
				CMD_WRITE: return 3 * DATA_BITS;
				CMD_READ:  return 2 * DATA_BITS + 1;
				CMD_SACK:  return 3;
				CMD_RACK:  return 4;
				default:   return 0;
			endcase
		endfunction

		function int waiting();
			return levels_due.size();
		endfunction

		// Advance the line sequence by one accepted request and queue its levels
		function void note_tick(input req_t r);
			rsp_t       want;
			int         bit_no;
			logic [4:0] q;
			want = '0;
			if (cmd_run == CMD_NONE) begin
				if (r.op >= CMD_START && r.op <= CMD_RACK) begin
					cmd_run = r.op;
					phase_idx = '0;
					case (r.op)
						CMD_WRITE: shifter = r.data_byte;
						CMD_SACK:  shifter = {{(DATA_BITS-1){1'b0}}, r.ack_value};
						default:   shifter = '0;
					endcase
				end
			end else if (r.op != CMD_NONE) begin
				want.command_ignored = 1'b1;
				dropped++;
			end
			if (cmd_run != CMD_NONE) begin
				case (cmd_run)
					CMD_START: begin
						case (phase_idx)
							5'd0:    sda = 1'b1;
							5'd1:    scl = 1'b1;
							5'd2:    sda = 1'b0;
							default: scl = 1'b0;
						endcase
					end
					CMD_STOP: begin
						case (phase_idx)
							5'd0:    sda = 1'b0;
							5'd1:    scl = 1'b1;
							default: sda = 1'b1;
						endcase
					end
					CMD_WRITE: begin
						bit_no = phase_idx / 3;
						case (phase_idx % 3)
							0:       sda = shifter[DATA_BITS-1-bit_no];
							1:       scl = 1'b1;
							default: scl = 1'b0;
						endcase
					end
					CMD_READ: begin
						if (phase_idx == 5'd0) begin
							sda = 1'b1;
						end else begin
							q = phase_idx - 5'd1;
							bit_no = q / 2;
							if (!q[0]) begin
								scl = 1'b1;
								if (r.sda_in)
									shifter[DATA_BITS-1-bit_no] = 1'b1;
							end else begin
								scl = 1'b0;
							end
						end
					end
					CMD_SACK: begin
						case (phase_idx)
							5'd0:    sda = shifter[0];
							5'd1:    scl = 1'b1;
							default: scl = 1'b0;
						endcase
					end
					CMD_RACK: begin
						case (phase_idx)
							5'd0:    sda = 1'b1;
							5'd1:    scl = 1'b1;
							5'd2:    ack_lvl = r.sda_in;
							default: scl = 1'b0;
						endcase
					end
					default: ;
				endcase
				phase_idx = phase_idx + 5'd1;
				if (phase_idx >= phase_total(cmd_run)) begin
					if (cmd_run == CMD_READ)
						rx_byte = shifter;
					want.done_res = 1'b1;
					finished[cmd_run]++;
					cmd_run = CMD_NONE;
					phase_idx = '0;
				end else begin
					want.busy_res = 1'b1;
				end
			end
			want.scl_level = scl;
			want.sda_level = sda;
			want.read_data = rx_byte;
			want.ack_seen = ack_lvl;
			levels_due.push_back(want);
		endfunction

		function void field_differs(input string name, input logic [7:0] want,
				input logic [7:0] got);
			if (want !== got) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d: %s expected %0h, got %0h", checked, name, want,
						got);
			end
		endfunction

		function void check_phase(input rsp_t got);
			rsp_t want;
			if (levels_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("phase result with nothing pending: %p", got);
				return;
			end
			want = levels_due.pop_front();
			checked++;
			field_differs("scl_level", 8'(want.scl_level), 8'(got.scl_level));
			field_differs("sda_level", 8'(want.sda_level), 8'(got.sda_level));
			field_differs("busy_res", 8'(want.busy_res), 8'(got.busy_res));
			field_differs("done_res", 8'(want.done_res), 8'(got.done_res));
			field_differs("read_data", want.read_data, got.read_data);
			field_differs("ack_seen", 8'(want.ack_seen), 8'(got.ack_seen));
			field_differs("command_ignored", 8'(want.command_ignored),
				8'(got.command_ignored));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	phase_board board = new();
	int         cycle_count = 0;
	int         ticks_sent = 0;
	int         idle_ticks = 0;
	int         burst_left = 0;
	int         stall_left = 0;
	int         stall_mode = 0;
	logic [7:0] stall_pattern = 8'b1100_1110;

	i2c_master_bit_sequencer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending", cycle_count,
				board.waiting());
			$display("i2c_master_bit_sequencer verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			board.check_phase(rsp);
	end

	// Receiver: switch between free flow, light random, fixed pattern and heavy stall
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(5, 60);
		end
		stall_left--;
		stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
		case (stall_mode)
			0:       rsp_stall <= 1'b0;
			1:       rsp_stall <= ($urandom_range(0, 3) == 0);
			2:       rsp_stall <= stall_pattern[0];
			default: rsp_stall <= ($urandom_range(0, 9) != 0);
		endcase
	end

	function automatic req_t tick_of(input logic [2:0] op, input logic [7:0] d,
			input logic a, input logic s);
		req_t t;
		t.op = op;
		t.data_byte = d;
		t.ack_value = a;
		t.sda_in = s;
		return t;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance
	task automatic send_tick(input req_t item);
		if (burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(80, 200) :
				$urandom_range(1, 30);
		end
		burst_left--;
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		board.note_tick(item);
		ticks_sent++;
		@(negedge clk);
	endtask

	// Hold off new requests until every queued result has been seen
	task automatic drain();
		req_valid <= 1'b0;
		do @(negedge clk); while (board.waiting() != 0);
	endtask

	// One command followed by its follow-on ticks, some carrying stray commands;
	// occasionally cut short so the next command lands while busy
	task automatic play_command(input logic [2:0] cmd);
		req_t item;
		int   sda_mode;
		int   n;
		item.op = cmd;
		case ($urandom_range(0, 3))
			0:       item.data_byte = 8'h00;
			1:       item.data_byte = 8'hFF;
			default: item.data_byte = 8'($urandom);
		endcase
		item.ack_value = 1'($urandom);
		sda_mode = $urandom_range(0, 3);
		n = board.phase_total(cmd);
		if ($urandom_range(0, 9) == 0)
			n = $urandom_range(1, n);
		for (int k = 0; k < n; k++) begin
			item.sda_in = (sda_mode == 1) ? 1'b1 : (sda_mode == 2) ? 1'b0 : 1'($urandom);
			send_tick(item);
			item.op = ($urandom_range(0, 11) == 0) ? 3'($urandom_range(1, 7)) : CMD_NONE;
			item.data_byte = 8'($urandom);
			item.ack_value = 1'($urandom);
		end
	endtask

	initial begin
		int pick;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: unused op while idle, start with stray commands while busy,
		// stop, both ack levels sent, both ack levels received
		send_tick(tick_of(OP_UNUSED, 8'hFF, 1'b1, 1'b1));
		send_tick(tick_of(CMD_NONE, 8'h00, 1'b0, 1'b0));
		send_tick(tick_of(CMD_START, 8'h00, 1'b0, 1'b0));
		send_tick(tick_of(OP_UNUSED, 8'h00, 1'b0, 1'b0));
		send_tick(tick_of(CMD_WRITE, 8'hFF, 1'b1, 1'b1));
		send_tick(tick_of(CMD_NONE, 8'h00, 1'b0, 1'b0));
		send_tick(tick_of(CMD_STOP, 8'h00, 1'b0, 1'b0));
		send_tick(tick_of(CMD_NONE, 8'h00, 1'b0, 1'b0));
		send_tick(tick_of(CMD_NONE, 8'h00, 1'b0, 1'b0));
		send_tick(tick_of(CMD_SACK, 8'h00, 1'b1, 1'b0));
		send_tick(tick_of(CMD_NONE, 8'h00, 1'b0, 1'b0));
		send_tick(tick_of(CMD_NONE, 8'h00, 1'b0, 1'b0));
		send_tick(tick_of(CMD_SACK, 8'hFF, 1'b0, 1'b1));
		send_tick(tick_of(CMD_NONE, 8'h00, 1'b0, 1'b0));
		send_tick(tick_of(CMD_NONE, 8'h00, 1'b0, 1'b0));
		send_tick(tick_of(CMD_RACK, 8'h00, 1'b0, 1'b1));
		send_tick(tick_of(CMD_NONE, 8'h00, 1'b0, 1'b1));
		send_tick(tick_of(CMD_NONE, 8'h00, 1'b0, 1'b0));
		send_tick(tick_of(CMD_NONE, 8'h00, 1'b0, 1'b1));
		send_tick(tick_of(CMD_RACK, 8'h00, 1'b0, 1'b0));
		send_tick(tick_of(CMD_NONE, 8'h00, 1'b0, 1'b0));
		send_tick(tick_of(CMD_NONE, 8'h00, 1'b0, 1'b1));
		send_tick(tick_of(CMD_NONE, 8'h00, 1'b0, 1'b0));
		drain();

		while (ticks_sent - idle_ticks < RANDOM_TICKS + 23) begin
			pick = $urandom_range(0, 99);
			if (pick < 30)
				play_command(CMD_WRITE);
			else if (pick < 55)
				play_command(CMD_READ);
			else if (pick < 65)
				play_command(CMD_START);
			else if (pick < 75)
				play_command(CMD_STOP);
			else if (pick < 85)
				play_command(CMD_SACK);
			else if (pick < 94)
				play_command(CMD_RACK);
			else begin
				send_tick(tick_of(($urandom_range(0, 1) == 0) ? CMD_NONE : OP_UNUSED,
					8'($urandom), 1'($urandom), 1'($urandom)));
				idle_ticks++;
			end
			if ($urandom_range(0, 39) == 0)
				drain();
		end

		req_valid <= 1'b0;
		while (board.waiting() != 0) @(negedge clk);
		repeat (8) @(negedge clk);

		$display("%0d ticks driven (%0d idle), %0d phase results checked, %0d dropped commands",
			ticks_sent, idle_ticks, board.checked, board.dropped);
		$display("completed: start %0d, stop %0d, write %0d, read %0d, ack out %0d, ack in %0d",
			board.finished[CMD_START], board.finished[CMD_STOP], board.finished[CMD_WRITE],
			board.finished[CMD_READ], board.finished[CMD_SACK], board.finished[CMD_RACK]);
		if (board.mismatches == 0 && board.waiting() == 0) begin
			$display("i2c_master_bit_sequencer verification clean");
		end else begin
			$display("%0d mismatches", board.mismatches);
			$display("i2c_master_bit_sequencer verification failed");
		end
		$finish;
	end

endmodule
